// ===== rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Word types for the command and result channels, and the token and
// broadcast structs that pass between the controller and the frame cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	// Field widths that bound the frame count and the stored page width.
	localparam int IDX_W      = 4;   // frame index or rank, up to 16 frames
	localparam int CNT_W      = 5;   // frame count, 0 to 16
	localparam int MAX_PAGE_W = 32;  // widest stored page number

	localparam logic [2:0] FIU_RESET = 3'd4;

	typedef struct packed {
		logic [15:0] page_number;
		logic        start_of_run;
	} cmd_t;

	typedef struct packed {
		logic        page_fault;
		logic [1:0]  frame_used;
		logic        evicted_valid;
		logic [15:0] evicted_page;
		logic [31:0] fault_total;
		logic [31:0] replace_total;
	} result_t;

	// Search token that walks down the chain, one cell per cycle.
	typedef struct packed {
		logic                  valid;
		logic                  hit;
		logic [IDX_W-1:0]      hit_idx;
		logic [IDX_W-1:0]      hit_rank;
		logic [IDX_W-1:0]      best_idx;
		logic [IDX_W-1:0]      best_rank;
		logic [MAX_PAGE_W-1:0] best_page;
	} token_t;

	// Controller to cells: search key, bounds and the recency update.
	typedef struct packed {
		logic                  clear;
		logic [MAX_PAGE_W-1:0] key;
		logic [CNT_W-1:0]      active;
		logic [CNT_W-1:0]      nf;
		logic                  upd;
		logic                  wr;
		logic [IDX_W-1:0]      k;
		logic [CNT_W-1:0]      limit;
		logic [CNT_W-1:0]      bound;
	} bcast_t;

endpackage

// ===== rtl/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame's page and recency rank, adds its own frame to the search
// token that passes through, and applies the broadcast recency update.
// ----------------------------------------------------------------------------
module lrupr_cell #(
	parameter int J          = 0,
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrupr_pkg::bcast_t bc,
	input  lrupr_pkg::token_t tok_in,
	output lrupr_pkg::token_t tok_out
);

	localparam int RANK_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam logic [lrupr_pkg::CNT_W-1:0] J_C      = lrupr_pkg::CNT_W'(J);
	localparam logic [lrupr_pkg::IDX_W-1:0] J_I      = lrupr_pkg::IDX_W'(J);
	localparam logic [lrupr_pkg::CNT_W-1:0] RANK_MAX = lrupr_pkg::CNT_W'(NUM_FRAMES - 1);

	logic [PAGE_BITS-1:0]        page_q;
	logic [RANK_W-1:0]           rank_q;
	lrupr_pkg::token_t           tok_q;
	lrupr_pkg::token_t           tok_d;
	logic [lrupr_pkg::CNT_W-1:0] rank_c;
	logic [lrupr_pkg::IDX_W-1:0] rank_i;

	assign rank_c = lrupr_pkg::CNT_W'(rank_q);
	assign rank_i = lrupr_pkg::IDX_W'(rank_q);

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && (J_C < bc.active) && (page_q == bc.key[PAGE_BITS-1:0])) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_idx  = J_I;
			tok_d.hit_rank = rank_i;
		end
		// Frame 0 always seeds the oldest-frame search, so an all-zero rank set picks it.
		if ((J_C < bc.nf) && ((J == 0) || (rank_i > tok_in.best_rank))) begin
			tok_d.best_idx  = J_I;
			tok_d.best_rank = rank_i;
			tok_d.best_page = lrupr_pkg::MAX_PAGE_W'(page_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (bc.clear) begin
			rank_q <= '0;
		end else if (bc.upd) begin
			if (bc.k == J_I) begin
				rank_q <= '0;
			end else if ((J_C < bc.bound) && (rank_c < bc.limit) && (rank_c < RANK_MAX)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bc.upd && bc.wr && (bc.k == J_I)) begin
			page_q <= bc.key[PAGE_BITS-1:0];
		end
	end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// Each access passes through an injection state, then a search token that walks the frame cell
// chain one cell per cycle, then the update; done is registered from the update. A new access
// is accepted only once the last one has finished and busy is low.
// Results are strobed for one cycle on done; the receiver cannot stall them.
// Reset clears counters, ranks and the fill count and sets frames_in_use to 4;
// frame pages stay undefined until a fault writes them.
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative frame set with least-recently-used replacement, fault and
// replacement counters, and an APB register for the number of frames in use.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lrupr_pkg::cmd_t    cmd,
	output logic               done,
	output lrupr_pkg::result_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic REG_FRAMES_IN_USE = 1'b0;
	localparam logic [lrupr_pkg::CNT_W-1:0] NF_C = lrupr_pkg::CNT_W'(NUM_FRAMES);

	typedef enum logic [1:0] {S_IDLE, S_INJ, S_WAIT} state_t;

	state_t                      state_q;
	logic [2:0]                  fiu_q;
	logic [PAGE_BITS-1:0]        key_q;
	logic [lrupr_pkg::CNT_W-1:0] filled_q;
	logic [31:0]                 fault_q;
	logic [31:0]                 repl_q;
	logic                        done_q;
	lrupr_pkg::result_t          result_q;

	lrupr_pkg::token_t           tok_w [0:NUM_FRAMES];
	lrupr_pkg::token_t           last;
	lrupr_pkg::bcast_t           bc;
	logic                        accept;
	logic                        finish;
	logic                        full;
	logic [lrupr_pkg::CNT_W-1:0] fe;
	logic [lrupr_pkg::CNT_W-1:0] act;
	logic [lrupr_pkg::CNT_W-1:0] fiu_c;
	logic [31:0]                 fault_n;
	logic [31:0]                 repl_n;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? 32'(fiu_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lrupr_pkg::FIU_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE)) begin
			fiu_q <= pwdata[2:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign last   = tok_w[NUM_FRAMES];
	assign finish = (state_q == S_WAIT) && last.valid;

	// Effective frame count: zero acts as one, anything above the cell count saturates.
	assign fiu_c = lrupr_pkg::CNT_W'(fiu_q);
	assign fe    = (fiu_q == 3'd0) ? lrupr_pkg::CNT_W'(1) : ((fiu_c > NF_C) ? NF_C : fiu_c);
	assign act   = (filled_q < fe) ? filled_q : fe;
	assign full  = !(filled_q < fe);

	assign fault_n = (fault_q == '1) ? fault_q : fault_q + 32'd1;
	assign repl_n  = (repl_q == '1) ? repl_q : repl_q + 32'd1;

	always_comb begin
		tok_w[0]       = '0;
		tok_w[0].valid = (state_q == S_INJ);

		bc        = '0;
		bc.clear  = accept && cmd.start_of_run;
		bc.key    = lrupr_pkg::MAX_PAGE_W'(key_q);
		bc.active = act;
		bc.nf     = fe;
		bc.upd    = finish;
		if (last.hit) begin
			bc.k     = last.hit_idx;
			bc.limit = lrupr_pkg::CNT_W'(last.hit_rank);
			bc.bound = act;
		end else if (!full) begin
			bc.wr    = 1'b1;
			bc.k     = lrupr_pkg::IDX_W'(filled_q);
			bc.limit = NF_C;
			bc.bound = filled_q + 1'b1;
		end else begin
			bc.wr    = 1'b1;
			bc.k     = last.best_idx;
			bc.limit = NF_C;
			bc.bound = fe;
		end
	end

	for (genvar j = 0; j < NUM_FRAMES; j++) begin : g_cell
		lrupr_cell #(
			.J          (j),
			.NUM_FRAMES (NUM_FRAMES),
			.PAGE_BITS  (PAGE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.tok_in  (tok_w[j]),
			.tok_out (tok_w[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			filled_q <= '0;
			fault_q  <= '0;
			repl_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_INJ;
						if (cmd.start_of_run) begin
							filled_q <= '0;
							fault_q  <= '0;
							repl_q   <= '0;
						end
					end
				end
				S_INJ: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (!last.hit) begin
							fault_q <= fault_n;
							if (!full) begin
								filled_q <= filled_q + 1'b1;
							end else begin
								repl_q <= repl_n;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= PAGE_BITS'(cmd.page_number);
		end
		if (finish) begin
			result_q.page_fault    <= !last.hit;
			result_q.frame_used    <= bc.k[1:0];
			result_q.evicted_valid <= !last.hit && full;
			result_q.evicted_page  <= (!last.hit && full) ? last.best_page[15:0] : 16'd0;
			result_q.fault_total   <= last.hit ? fault_q : fault_n;
			result_q.replace_total <= (!last.hit && full) ? repl_n : repl_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/lrupr_chk.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
module lrupr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input lrupr_pkg::result_t result
);

	// A result word only appears once the block has gone idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted access did not hold the block busy");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.evicted_valid) |-> result.page_fault)
		else $error("eviction reported without a fault");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.evicted_valid) |-> (result.evicted_page == 16'd0))
		else $error("evicted page nonzero without an eviction");

	a_repl_le_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.replace_total <= result.fault_total))
		else $error("replacement count exceeds fault count");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
